[rtl/core/dfuf_pkg.sv]
// Shared types and constants of the dual forest union-find block.
`default_nettype none
package dfuf_pkg;

	localparam int unsigned NODES  = 1024;
	localparam int unsigned NODE_W = $clog2(NODES);

	typedef logic [NODE_W-1:0] node_t;

	// operation kinds
	localparam logic [1:0] K_MERGE_A = 2'd0;
	localparam logic [1:0] K_MERGE_B = 2'd1;
	localparam logic [1:0] K_JOIN    = 2'd2;

	// controller to forest unit
	typedef struct packed {
		logic  start;
		node_t node;
		logic  wr;
		node_t wr_addr;
		node_t wr_data;
	} fu_req_t;

	// forest unit to controller
	typedef struct packed {
		logic  ready;
		logic  done;
		node_t root;
	} fu_rsp_t;

endpackage
`default_nettype wire

[rtl/core/dfuf_forest.sv]
// One forest: link memory, clearing pass, find with path compression, merge write.
`default_nettype none
module dfuf_forest (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dfuf_pkg::fu_req_t req,
	output dfuf_pkg::fu_rsp_t      rsp
);

	typedef enum logic [3:0] {
		F_CLR  = 4'b0001,
		F_IDLE = 4'b0010,
		F_WALK = 4'b0100,
		F_COMP = 4'b1000
	} fstate_t;

	localparam dfuf_pkg::node_t LAST = dfuf_pkg::node_t'(dfuf_pkg::NODES - 1);

	dfuf_pkg::node_t link_mem [dfuf_pkg::NODES];

	fstate_t         state_q, state_d;
	dfuf_pkg::node_t clr_q, clr_d;
	dfuf_pkg::node_t node_q, node_d;
	dfuf_pkg::node_t root_q, root_d;
	dfuf_pkg::node_t cur_q, cur_d;
	logic            done_q, done_d;
	dfuf_pkg::node_t rdata_q;

	logic            re, we;
	dfuf_pkg::node_t raddr, waddr, wdata;

	always_comb begin
		state_d = state_q;
		clr_d   = clr_q;
		node_d  = node_q;
		root_d  = root_q;
		cur_d   = cur_q;
		done_d  = 1'b0;
		re      = 1'b0;
		raddr   = '0;
		we      = 1'b0;
		waddr   = '0;
		wdata   = '0;
		unique case (state_q)
			F_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = clr_q;
				clr_d = clr_q + dfuf_pkg::node_t'(1);
				if (clr_q == LAST) state_d = F_IDLE;
			end
			F_IDLE: begin
				if (req.start) begin
					re      = 1'b1;
					raddr   = req.node;
					node_d  = req.node;
					root_d  = req.node;
					state_d = F_WALK;
				end else if (req.wr) begin
					we    = 1'b1;
					waddr = req.wr_addr;
					wdata = req.wr_data;
				end
			end
			F_WALK: begin
				// rdata_q = link of root_q
				if (rdata_q == root_q) begin
					if (node_q == root_q) begin
						done_d  = 1'b1;
						state_d = F_IDLE;
					end else begin
						re      = 1'b1;
						raddr   = node_q;
						cur_d   = node_q;
						state_d = F_COMP;
					end
				end else begin
					root_d = rdata_q;
					re     = 1'b1;
					raddr  = rdata_q;
				end
			end
			F_COMP: begin
				// rdata_q = old link of cur_q; repoint cur_q at the root
				we    = 1'b1;
				waddr = cur_q;
				wdata = root_q;
				if (rdata_q == root_q) begin
					done_d  = 1'b1;
					state_d = F_IDLE;
				end else begin
					cur_d = rdata_q;
					re    = 1'b1;
					raddr = rdata_q;
				end
			end
			default: state_d = F_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_CLR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		node_q <= node_d;
		root_q <= root_d;
		cur_q  <= cur_d;
	end

	always_ff @(posedge clk) begin
		if (we) link_mem[waddr] <= wdata;
		if (re) rdata_q <= link_mem[raddr];
	end

	assign rsp.ready = (state_q != F_CLR);
	assign rsp.done  = done_q;
	assign rsp.root  = root_q;

endmodule
`default_nettype wire

[rtl/core/dual_forest_union_find.sv]
// Top level: two union-find forests with a shared item controller.
//
// Input channel (in_valid/in_ready) takes one word: kind, node_a, node_b.
// Output channel (out_valid/out_ready) gives one word per input word:
// linked_in_a, linked_in_b (connectivity before the operation) and joined.
// Kind 0 merges in forest A, kind 1 in forest B, kind 2 merges in both only
// if the nodes are unconnected in both; kind 3 only reports.
// Each forest has its own link memory (one read, one write port, registered
// read). A find walks parent links one per cycle and then walks the path
// again, repointing each node at the root. Both forests run in parallel, so
// one word waits for the slower forest's find of node_a, then of node_b,
// with an accept step before them and the merge and result-load steps after.
// One word is worked on at a time; in_ready is high only while idle.
// After reset both memories are cleared (each node its own root) by a pass
// over all NODES (1024) entries during which in_ready stays low.
// The result sits in an output register; a stalled receiver holds it there
// while the next word may already be accepted and worked on, which then
// waits for the register to empty before it is delivered.
`default_nettype none
module dual_forest_union_find (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] kind,
	input  wire logic [9:0] node_a,
	input  wire logic [9:0] node_b,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            linked_in_a,
	output logic            linked_in_b,
	output logic            joined
);

	typedef enum logic [5:0] {
		S_CLR  = 6'b000001,
		S_IDLE = 6'b000010,
		S_FA   = 6'b000100,
		S_FB   = 6'b001000,
		S_MRG  = 6'b010000,
		S_RES  = 6'b100000
	} state_t;

	state_t state_q;
	logic   go_q;
	logic   dn_a_q, dn_b_q;
	logic   bad_q;
	logic   out_valid_q, la_q, lb_q, jn_q;

	logic [1:0]      kind_q;
	dfuf_pkg::node_t na_q, nb_q;
	dfuf_pkg::node_t ra_a_q, ra_b_q, rb_a_q, rb_b_q;

	dfuf_pkg::fu_req_t req_a, req_b;
	dfuf_pkg::fu_rsp_t rsp_a, rsp_b;

	logic in_acc, bad_in, both_done, la, lb, mrg_a, mrg_b, res_ld;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	// node beyond the node set: no state change, all-zero result
	assign bad_in   = (32'(node_a) >= dfuf_pkg::NODES) || (32'(node_b) >= dfuf_pkg::NODES);

	assign both_done = (dn_a_q || rsp_a.done) && (dn_b_q || rsp_b.done);

	assign la    = (ra_a_q == rb_a_q);
	assign lb    = (ra_b_q == rb_b_q);
	assign mrg_a = (kind_q == dfuf_pkg::K_MERGE_A) || ((kind_q == dfuf_pkg::K_JOIN) && !la && !lb);
	assign mrg_b = (kind_q == dfuf_pkg::K_MERGE_B) || ((kind_q == dfuf_pkg::K_JOIN) && !la && !lb);

	assign res_ld = (state_q == S_RES) && (!out_valid_q || out_ready);

	// finds: node_a in both forests, then node_b in both forests
	always_comb begin
		req_a.start   = go_q;
		req_a.node    = (state_q == S_FB) ? nb_q : na_q;
		req_a.wr      = (state_q == S_MRG) && mrg_a && !la;
		// larger root points at the smaller one
		req_a.wr_addr = (ra_a_q > rb_a_q) ? ra_a_q : rb_a_q;
		req_a.wr_data = (ra_a_q > rb_a_q) ? rb_a_q : ra_a_q;

		req_b.start   = go_q;
		req_b.node    = (state_q == S_FB) ? nb_q : na_q;
		req_b.wr      = (state_q == S_MRG) && mrg_b && !lb;
		req_b.wr_addr = (ra_b_q > rb_b_q) ? ra_b_q : rb_b_q;
		req_b.wr_data = (ra_b_q > rb_b_q) ? rb_b_q : ra_b_q;
	end

	dfuf_forest u_forest_a (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_a),
		.rsp    (rsp_a)
	);

	dfuf_forest u_forest_b (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_b),
		.rsp    (rsp_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			go_q        <= 1'b0;
			dn_a_q      <= 1'b0;
			dn_b_q      <= 1'b0;
			bad_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					if (rsp_a.ready && rsp_b.ready) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_acc) begin
						bad_q  <= bad_in;
						dn_a_q <= 1'b0;
						dn_b_q <= 1'b0;
						if (bad_in) begin
							state_q <= S_RES;
						end else begin
							go_q    <= 1'b1;
							state_q <= S_FA;
						end
					end
				end
				S_FA, S_FB: begin
					if (rsp_a.done) dn_a_q <= 1'b1;
					if (rsp_b.done) dn_b_q <= 1'b1;
					if (both_done) begin
						dn_a_q <= 1'b0;
						dn_b_q <= 1'b0;
						if (state_q == S_FA) begin
							go_q    <= 1'b1;
							state_q <= S_FB;
						end else begin
							state_q <= S_MRG;
						end
					end
				end
				S_MRG: begin
					state_q <= S_RES;
				end
				S_RES: begin
					if (res_ld) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_CLR;
			endcase
		end
	end

	// word and result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q <= kind;
			na_q   <= dfuf_pkg::node_t'(node_a);
			nb_q   <= dfuf_pkg::node_t'(node_b);
		end
		if ((state_q == S_FA) && both_done) begin
			ra_a_q <= rsp_a.root;
			ra_b_q <= rsp_b.root;
		end
		if ((state_q == S_FB) && both_done) begin
			rb_a_q <= rsp_a.root;
			rb_b_q <= rsp_b.root;
		end
		if (res_ld) begin
			la_q <= !bad_q && la;
			lb_q <= !bad_q && lb;
			jn_q <= !bad_q && (kind_q == dfuf_pkg::K_JOIN) && !la && !lb;
		end
	end

	assign out_valid   = out_valid_q;
	assign linked_in_a = la_q;
	assign linked_in_b = lb_q;
	assign joined      = jn_q;

`ifndef ASSERT_OFF
	// words are only taken once both memories are cleared
	a_clear_before_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> (rsp_a.ready && rsp_b.ready))
		else $error("word accepted before clearing pass finished");

	// a forest A merge never points a node at a larger node
	a_merge_order_a: assert property (@(posedge clk) disable iff (!arst_n)
		req_a.wr |-> (req_a.wr_data < req_a.wr_addr))
		else $error("forest A merge points root at larger node");

	// find completions only arrive while a find round is open
	a_done_in_find: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_a.done || rsp_b.done) |-> (state_q == S_FA || state_q == S_FB))
		else $error("find completion outside a find round");

	// a join is only reported for nodes unconnected in both forests
	a_join_unlinked: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && joined) |-> (!linked_in_a && !linked_in_b))
		else $error("join reported for linked nodes");
`endif

endmodule
`default_nettype wire

[bench/tb_dual_forest_union_find.sv]
// Testbench for dual_forest_union_find: predicts both forests and checks every result word.
`timescale 1ns / 1ps
module tb_dual_forest_union_find;

	// Kind 3 has no name in the package: it only reports connectivity.
	localparam logic [1:0] K_REPORT = 2'd3;
	localparam int FOREST_A = 0;
	localparam int FOREST_B = 1;

	// Gaps, stalls and the long receiver hold-off all land well inside this.
	localparam longint RUN_LIMIT_NS = 64'd8_000_000;
	// Cycles to watch for stray output words once nothing is expected.
	localparam int SETTLE_CYCLES = 64;

	typedef struct packed {
		logic linked_a;
		logic linked_b;
		logic joined;
	} verdict_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] kind;
	logic [9:0] node_a;
	logic [9:0] node_b;
	logic       out_valid;
	logic       out_ready;
	logic       linked_in_a;
	logic       linked_in_b;
	logic       joined;

	dual_forest_union_find dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.node_a     (node_a),
		.node_b     (node_b),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.linked_in_a(linked_in_a),
		.linked_in_b(linked_in_b),
		.joined     (joined)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predicted parent links of both forests, same layout as after the clearing pass.
	dfuf_pkg::node_t parent [2][dfuf_pkg::NODES];
	verdict_t        pending_verdicts [$];
	int              mismatches = 0;

	// Traffic shaping shared by the sender, the receiver and the tests.
	bit calm = 1'b0;       // no idling on either side
	int hold_len = 0;      // requested receiver hold-off, in cycles
	bit hold_busy = 1'b0;  // receiver is inside that hold-off

	// Walk to the root, then point every node on the walked path at it.
	function automatic dfuf_pkg::node_t find_compress(input int f, input dfuf_pkg::node_t n);
		dfuf_pkg::node_t r;
		dfuf_pkg::node_t cur;
		dfuf_pkg::node_t nxt;
		r = n;
		while (parent[f][r] != r)
			r = parent[f][r];
		cur = n;
		while (cur != r) begin
			nxt = parent[f][cur];
			parent[f][cur] = r;
			cur = nxt;
		end
		return r;
	endfunction

	// The larger root is hung under the smaller one.
	function automatic void unite(input int f, input dfuf_pkg::node_t x,
			input dfuf_pkg::node_t y);
		dfuf_pkg::node_t rx;
		dfuf_pkg::node_t ry;
		rx = find_compress(f, x);
		ry = find_compress(f, y);
		if (rx < ry)
			parent[f][ry] = rx;
		else
			parent[f][rx] = ry;
	endfunction

	function automatic verdict_t predict_word(input logic [1:0] k, input dfuf_pkg::node_t a,
			input dfuf_pkg::node_t b);
		verdict_t v;
		v.linked_a = (find_compress(FOREST_A, a) == find_compress(FOREST_A, b));
		v.linked_b = (find_compress(FOREST_B, a) == find_compress(FOREST_B, b));
		v.joined   = 1'b0;
		case (k)
			dfuf_pkg::K_MERGE_A: unite(FOREST_A, a, b);
			dfuf_pkg::K_MERGE_B: unite(FOREST_B, a, b);
			dfuf_pkg::K_JOIN: begin
				if (!v.linked_a && !v.linked_b) begin
					unite(FOREST_A, a, b);
					unite(FOREST_B, a, b);
					v.joined = 1'b1;
				end
			end
			default: ; // report only
		endcase
		return v;
	endfunction

	task automatic report_mismatch(input string what, input logic got, input logic want);
		$display("[%0t] mismatch on %s: got %b, expected %b", $time, what, got, want);
		mismatches++;
	endtask

	// Result check: every accepted output word against the oldest prediction.
	always @(posedge clk) begin : check_results
		verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				report_mismatch("out_valid with no word outstanding", 1'b1, 1'b0);
			end else begin
				want = pending_verdicts.pop_front();
				if (linked_in_a !== want.linked_a)
					report_mismatch("linked_in_a", linked_in_a, want.linked_a);
				if (linked_in_b !== want.linked_b)
					report_mismatch("linked_in_b", linked_in_b, want.linked_b);
				if (joined !== want.joined)
					report_mismatch("joined", joined, want.joined);
			end
		end
	end

	// Receiver: random stall bursts, or a long hold-off when a test asks for one.
	initial begin : drive_out_ready
		int n;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_len != 0) begin
				out_ready <= 1'b0;
				hold_busy = 1'b1;
				n = hold_len;
				repeat (n) @(negedge clk);
				hold_len = 0;
				hold_busy = 1'b0;
				out_ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				out_ready <= 1'b0;
				n = $urandom_range(1, 17);
				repeat (n) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offer one word, possibly after a random gap, and log its prediction on acceptance.
	// Valid stays high between back-to-back words.
	task automatic send_word(input logic [1:0] k, input dfuf_pkg::node_t a,
			input dfuf_pkg::node_t b);
		int       n;
		verdict_t v;
		@(negedge clk);
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			n = $urandom_range(1, 17);
			repeat (n) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		node_a   <= a;
		node_b   <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		v = predict_word(k, a, b);
		pending_verdicts.insert(pending_verdicts.size(), v);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Extremes of the node range, every kind, same node twice, already-connected merges.
	task automatic test_directed_edges();
		send_word(K_REPORT,            10'd0,    10'd1023);
		send_word(dfuf_pkg::K_MERGE_A, 10'd0,    10'd0);
		send_word(dfuf_pkg::K_MERGE_A, 10'd1023, 10'd0);
		send_word(K_REPORT,            10'd0,    10'd1023);
		send_word(dfuf_pkg::K_JOIN,    10'd0,    10'd1023);   // linked in A: no join
		send_word(dfuf_pkg::K_MERGE_B, 10'd1023, 10'd512);
		send_word(dfuf_pkg::K_JOIN,    10'd5,    10'd6);      // fresh pair: joins
		send_word(dfuf_pkg::K_JOIN,    10'd6,    10'd5);      // now linked in both
		send_word(dfuf_pkg::K_JOIN,    10'd2,    10'd2);
		send_word(K_REPORT,            10'h155,  10'h2AA);
	endtask

	// Merging downward builds a long chain; the next find walks it and flattens it.
	task automatic test_deep_chain();
		for (int k = 20; k >= 10; k--)
			send_word(dfuf_pkg::K_MERGE_A, dfuf_pkg::node_t'(k), dfuf_pkg::node_t'(k + 1));
		send_word(K_REPORT,            10'd21, 10'd10);
		send_word(dfuf_pkg::K_JOIN,    10'd21, 10'd600);
		send_word(dfuf_pkg::K_MERGE_B, 10'd21, 10'd10);
	endtask

	// Words drawn mostly from a moving window so that sets grow and links show up.
	task automatic send_random_word(inout dfuf_pkg::node_t cluster_base);
		logic [1:0]      k;
		dfuf_pkg::node_t a;
		dfuf_pkg::node_t b;
		int              pick;
		if ($urandom_range(0, 39) == 0)
			cluster_base = dfuf_pkg::node_t'($urandom_range(0, dfuf_pkg::NODES - 1));
		pick = $urandom_range(0, 9);
		k = (pick < 3) ? dfuf_pkg::K_MERGE_A : (pick < 6) ? dfuf_pkg::K_MERGE_B :
			(pick < 9) ? dfuf_pkg::K_JOIN : K_REPORT;
		pick = $urandom_range(0, 19);
		if (pick < 9) begin
			a = dfuf_pkg::node_t'(cluster_base + $urandom_range(0, 23));
			b = dfuf_pkg::node_t'(cluster_base + $urandom_range(0, 23));
		end else if (pick < 11) begin
			a = dfuf_pkg::node_t'($urandom_range(0, dfuf_pkg::NODES - 1));
			b = a;
		end else begin
			a = dfuf_pkg::node_t'($urandom_range(0, dfuf_pkg::NODES - 1));
			b = dfuf_pkg::node_t'($urandom_range(0, dfuf_pkg::NODES - 1));
		end
		send_word(k, a, b);
	endtask

	task automatic test_random_mix(input int count, inout dfuf_pkg::node_t cluster_base);
		for (int i = 0; i < count; i++)
			send_random_word(cluster_base);
	endtask

	// Receiver holds off long enough that the block fills and drops in_ready.
	task automatic test_output_holdoff(inout dfuf_pkg::node_t cluster_base);
		hold_len = 300;
		wait (hold_busy);
		test_random_mix(20, cluster_base);
	endtask

	// Sender goes quiet until every outstanding word has come back.
	task automatic test_drain_pause(inout dfuf_pkg::node_t cluster_base);
		test_random_mix(10, cluster_base);
		stop_sending();
		wait (pending_verdicts.size() == 0);
		test_random_mix(10, cluster_base);
	endtask

	// Last stretch: both sides run flat out.
	task automatic test_no_idle_tail(inout dfuf_pkg::node_t cluster_base);
		calm = 1'b1;
		test_random_mix(80, cluster_base);
	endtask

	initial begin : run_tests
		dfuf_pkg::node_t cluster_base;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		kind     = dfuf_pkg::K_MERGE_A;
		node_a   = '0;
		node_b   = '0;
		for (int i = 0; i < dfuf_pkg::NODES; i++) begin
			parent[FOREST_A][i] = dfuf_pkg::node_t'(i);
			parent[FOREST_B][i] = dfuf_pkg::node_t'(i);
		end
		cluster_base = dfuf_pkg::node_t'($urandom_range(0, dfuf_pkg::NODES - 1));
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// send_word waits on in_ready, so the clearing pass is absorbed there.
		test_directed_edges();
		test_deep_chain();
		test_output_holdoff(cluster_base);
		test_drain_pause(cluster_base);
		test_random_mix(900, cluster_base);
		test_no_idle_tail(cluster_base);
		stop_sending();

		wait (pending_verdicts.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin : run_limit
		#(RUN_LIMIT_NS);
		$display("Verification failed");
		$finish;
	end

endmodule

[dual_forest_union_find.f]
rtl/core/dfuf_pkg.sv
rtl/core/dfuf_forest.sv
rtl/core/dual_forest_union_find.sv
bench/tb_dual_forest_union_find.sv
